// ===== src/rsput_pkg.sv =====
package rsput_pkg;

	localparam int ACT_W = 1;
	localparam int POS_W = 10;
	localparam int VAL_W = 32;
	localparam int LEN_W = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam int MAX_ELEMENTS_DEF = 1024;
	localparam logic [LEN_W-1:0] LENGTH_RESET = 11'd1024;

	localparam logic [PADDR_W-3:0] REG_LENGTH = 1'b0;

	typedef enum logic [ACT_W-1:0] {
		ACT_WRITE = 1'b0,
		ACT_QUERY = 1'b1
	} action_t;

	typedef enum logic {
		ST_OK    = 1'b0,
		ST_RANGE = 1'b1
	} status_t;

endpackage

// ===== src/rsput_req_if.sv =====
interface rsput_req_if;
	import rsput_pkg::*;

	logic                    valid;
	logic                    ready;
	action_t                 action;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        range_start;
	logic [POS_W-1:0]        range_end;

	modport source (
		output valid, action, position, value, range_start, range_end,
		input  ready
	);

	modport sink (
		input  valid, action, position, value, range_start, range_end,
		output ready
	);

endinterface

// ===== src/rsput_rsp_if.sv =====
interface rsput_rsp_if;
	import rsput_pkg::*;

	logic                    valid;
	logic                    ready;
	logic signed [VAL_W-1:0] sum;
	status_t                 status;

	modport source (
		output valid, sum, status,
		input  ready
	);

	modport sink (
		input  valid, sum, status,
		output ready
	);

endinterface

// ===== src/rsput_ram.sv =====
module rsput_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/range_sum_point_update_tree.sv =====
// Channel  Dir  Payload                                        Handshake
// req      in   action, position, value, range_start, range_end  valid/ready
// rsp      out  sum, status                                    valid/ready
// apb      in   length register at byte address 0              psel/penable, pready=1
//
// After reset a clearing pass writes zero to all 2*MAX_ELEMENTS tree nodes,
// one node per cycle; req.ready stays low until it ends.
// A write walks up the tree one level per step, set by
// the single read port of the node memory (read sibling, write parent).
// A query reads up to two nodes per tree level.
// Rejected items and reversed ranges go straight to the result state.
// The result sits in an output register, so the next transaction is taken while
// rsp waits; a stalled rsp holds the block only when a second result is ready.
module range_sum_point_update_tree #(
	parameter int MAX_ELEMENTS = rsput_pkg::MAX_ELEMENTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rsput_pkg::PADDR_W-1:0]  paddr,
	input  logic [rsput_pkg::PDATA_W-1:0]  pwdata,
	output logic [rsput_pkg::PDATA_W-1:0]  prdata,
	output logic                           pready,
	rsput_req_if.sink                      req,
	rsput_rsp_if.source                    rsp
);
	import rsput_pkg::*;

	localparam int DEPTH = 2 * MAX_ELEMENTS;
	localparam int AW    = $clog2(DEPTH);
	localparam int NW    = $clog2(DEPTH + 1);
	localparam int LW    = $clog2(MAX_ELEMENTS + 1);
	localparam int NLW   = (LW > LEN_W) ? LW : LEN_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_WLEAF,
		S_WUP,
		S_QTOP,
		S_QRIGHT,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           clr_q;
	logic [LEN_W-1:0]        length_q;
	logic [AW-1:0]           k_q;
	logic [VAL_W-1:0]        cur_q;
	logic [NW-1:0]           a_q;
	logic [NW-1:0]           b_q;
	logic [VAL_W-1:0]        acc_q;
	logic                    pend_q;
	logic [VAL_W-1:0]        res_sum_q;
	status_t                 res_status_q;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        out_sum_q;
	status_t                 out_status_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [VAL_W-1:0]        ram_wdata;
	logic [AW-1:0]           ram_raddr;
	logic [VAL_W-1:0]        ram_rdata;

	logic [NLW-1:0]          eff_len;
	logic                    cfg_wr;
	logic                    req_fire;
	logic                    pos_bad;
	logic                    qry_bad;
	logic [AW-1:0]           parent;
	logic [VAL_W-1:0]        up_sum;
	logic [VAL_W-1:0]        acc_next;
	logic [NW-1:0]           a_inc;
	logic [NW-1:0]           b_dec;
	logic                    out_free;

	rsput_ram #(
		.WIDTH (VAL_W),
		.DEPTH (DEPTH)
	) u_node_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite
		&& (paddr[PADDR_W-1:2] == REG_LENGTH);
	assign prdata = (paddr[PADDR_W-1:2] == REG_LENGTH) ?
		PDATA_W'(length_q) : '0;

	assign eff_len = (NLW'(length_q) < NLW'(MAX_ELEMENTS)) ?
		NLW'(length_q) : NLW'(MAX_ELEMENTS);
	assign pos_bad = NLW'(req.position) >= eff_len;
	assign qry_bad = (NLW'(req.range_start) >= eff_len)
		|| (NLW'(req.range_end) >= eff_len);

	assign req.ready = (state_q == S_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign parent   = {1'b0, k_q[AW-1:1]};
	assign up_sum   = cur_q + ram_rdata;
	assign acc_next = acc_q + (pend_q ? ram_rdata : '0);
	assign a_inc    = a_q + NW'(1);
	assign b_dec    = b_q - NW'(1);
	assign out_free = !out_valid_q || rsp.ready;

	assign rsp.valid  = out_valid_q;
	assign rsp.sum    = out_sum_q;
	assign rsp.status = out_status_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = k_q;
		ram_wdata = cur_q;
		ram_raddr = k_q ^ AW'(1);
		unique case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			S_WLEAF: begin
				ram_we = 1'b1;
			end
			S_WUP: begin
				ram_we    = 1'b1;
				ram_waddr = parent;
				ram_wdata = up_sum;
				ram_raddr = parent ^ AW'(1);
			end
			S_QTOP: begin
				ram_raddr = a_q[AW-1:0];
			end
			S_QRIGHT: begin
				ram_raddr = b_dec[AW-1:0];
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			length_q     <= LENGTH_RESET;
			k_q          <= '0;
			cur_q        <= '0;
			a_q          <= '0;
			b_q          <= '0;
			acc_q        <= '0;
			pend_q       <= 1'b0;
			res_sum_q    <= '0;
			res_status_q <= ST_OK;
			out_valid_q  <= 1'b0;
			out_sum_q    <= '0;
			out_status_q <= ST_OK;
		end else begin
			if (cfg_wr) begin
				length_q <= pwdata[LEN_W-1:0];
			end
			if (out_valid_q && rsp.ready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req_fire) begin
						res_sum_q    <= '0;
						res_status_q <= ST_OK;
						acc_q        <= '0;
						pend_q       <= 1'b0;
						k_q          <= AW'(req.position) + AW'(MAX_ELEMENTS);
						cur_q        <= req.value;
						a_q          <= NW'(req.range_start) + NW'(MAX_ELEMENTS);
						b_q          <= NW'(req.range_end) + NW'(MAX_ELEMENTS) + NW'(1);
						if (req.action == ACT_WRITE) begin
							if (pos_bad) begin
								res_status_q <= ST_RANGE;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_WLEAF;
							end
						end else begin
							if (qry_bad) begin
								res_status_q <= ST_RANGE;
								state_q      <= S_DONE;
							end else if (req.range_start > req.range_end) begin
								state_q <= S_DONE;
							end else begin
								state_q <= S_QTOP;
							end
						end
					end
				end
				S_WLEAF: begin
					state_q <= S_WUP;
				end
				S_WUP: begin
					k_q   <= parent;
					cur_q <= up_sum;
					if (parent == AW'(1)) begin
						state_q <= S_DONE;
					end
				end
				S_QTOP: begin
					acc_q <= acc_next;
					if (a_q < b_q) begin
						pend_q  <= a_q[0];
						if (a_q[0]) begin
							a_q <= a_inc;
						end
						state_q <= S_QRIGHT;
					end else begin
						res_sum_q <= acc_next;
						state_q   <= S_DONE;
					end
				end
				S_QRIGHT: begin
					acc_q  <= acc_next;
					pend_q <= b_q[0];
					a_q    <= a_q >> 1;
					if (b_q[0]) begin
						b_q <= b_dec >> 1;
					end else begin
						b_q <= b_q >> 1;
					end
					state_q <= S_QTOP;
				end
				S_DONE: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_sum_q    <= res_sum_q;
						out_status_q <= res_status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
